@@ hdl/topk_softmax_gating_router_core_macros.svh @@
// Assertion macros for the router RTL.
`ifndef TOPK_SOFTMAX_GATING_ROUTER_CORE_MACROS_SVH
`define TOPK_SOFTMAX_GATING_ROUTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TSGR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("router check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define TSGR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("router check failed");

`endif

@@ hdl/tsgr_pkg.sv @@
package tsgr_pkg;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_ELEMENT = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e            op;
    logic [7:0]         row;
    logic [3:0]         col;
    logic signed [15:0] value;
    logic               last;
  } item_t;

  localparam logic [1:0] CFG_EXPERT_COUNT = 2'd0;
  localparam logic [1:0] CFG_SELECT_COUNT = 2'd1;

  localparam int ACC_W      = 40;
  localparam int DIFF_LIMIT = 4096;
  localparam int LOG2E_Q16  = 94548;

  // 65536 * 2^(-i/16), rounded
  function automatic logic [16:0] pow2_frac(input logic [4:0] i);
    logic [16:0] r;
    case (i)
      5'd0:    r = 17'd65536;
      5'd1:    r = 17'd62757;
      5'd2:    r = 17'd60097;
      5'd3:    r = 17'd57549;
      5'd4:    r = 17'd55109;
      5'd5:    r = 17'd52773;
      5'd6:    r = 17'd50535;
      5'd7:    r = 17'd48393;
      5'd8:    r = 17'd46341;
      5'd9:    r = 17'd44376;
      5'd10:   r = 17'd42495;
      5'd11:   r = 17'd40693;
      5'd12:   r = 17'd38968;
      5'd13:   r = 17'd37316;
      5'd14:   r = 17'd35734;
      5'd15:   r = 17'd34219;
      default: r = 17'd32768;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/tsgr_front.sv @@
module tsgr_front #(
  parameter int MAX_EXPERTS     = 16,
  parameter int MAX_MODEL_WIDTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          weight_row_i,
  input  logic [3:0]          weight_expert_i,
  input  logic signed [15:0]  value_i,
  input  logic                last_i,
  output logic                q_valid_o,
  output tsgr_pkg::item_t     q_item_o,
  input  logic                q_pop_i
);
  import tsgr_pkg::*;

  item_t      fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       keep, push;
  opcode_e    op;

  assign op   = opcode_e'(opcode_i);
  assign busy = (count_q == 2'd2);

  // drop unused opcodes and out-of-range weight writes here
  always_comb begin
    case (op)
      OP_ELEMENT, OP_CLEAR: keep = 1'b1;
      OP_WRITE: keep = (int'(weight_row_i) < MAX_MODEL_WIDTH) &&
                       (int'(weight_expert_i) < MAX_EXPERTS);
      default: keep = 1'b0;
    endcase
  end

  assign push      = start && !busy && keep;
  assign q_valid_o = (count_q != 2'd0);
  assign q_item_o  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{op: op, row: weight_row_i, col: weight_expert_i,
                            value: value_i, last: last_i};
    end
  end

endmodule

@@ hdl/tsgr_div.sv @@
module tsgr_div #(
  parameter int NW = 34,
  parameter int DW = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] num_q;
  logic [DW-1:0] den_q, rem_q;
  logic [DW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_q, num_q[NW-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});
  assign done_o = done_q;
  assign quo_o  = num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (int'(cnt_q) == NW - 1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one quotient bit a cycle, shifted into the numerator register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
      num_q <= {num_q[NW-2:0], ge};
    end
  end

endmodule

@@ hdl/tsgr_back.sv @@
`include "topk_softmax_gating_router_core_macros.svh"

module tsgr_back #(
  parameter int MAX_EXPERTS     = 16,
  parameter int MAX_MODEL_WIDTH = 256,
  parameter int MAX_SELECT      = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  tsgr_pkg::item_t q_item_i,
  output logic            q_pop_o,
  input  logic [4:0]      expert_count_i,
  input  logic [2:0]      select_count_i,
  output logic            result_valid_o,
  output logic [3:0]      expert_index_o,
  output logic [15:0]     gate_weight_o,
  output logic [1:0]      rank_o,
  output logic [31:0]     usage_count_o,
  output logic            final_choice_o
);
  import tsgr_pkg::*;

  localparam int EW  = $clog2(MAX_EXPERTS);
  localparam int ECW = $clog2(MAX_EXPERTS + 1);
  localparam int PW  = $clog2(MAX_MODEL_WIDTH + 1);
  localparam int AW  = $clog2(MAX_MODEL_WIDTH * MAX_EXPERTS);
  localparam int SCW = $clog2(MAX_SELECT + 1);
  localparam int KW  = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1;
  localparam int SW  = 17 + $clog2(MAX_SELECT + 1);
  localparam int NW  = 34;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ACC  = 6'b000010,
    ST_SEL  = 6'b000100,
    ST_EXPA = 6'b001000,
    ST_EXPB = 6'b010000,
    ST_DIV  = 6'b100000
  } state_e;

  state_e state_q;

  logic [15:0]           wmem [MAX_MODEL_WIDTH * MAX_EXPERTS];
  logic [15:0]           rdata_q;
  logic [AW-1:0]         raddr, waddr;
  logic                  wr_en;

  logic [ACC_W-1:0]      acc_q   [MAX_EXPERTS];
  logic [31:0]           usage_q [MAX_EXPERTS];
  logic [PW-1:0]         pos_q;
  logic [ECW-1:0]        e_q;
  logic [KW-1:0]         k_q;
  logic [MAX_EXPERTS-1:0] taken_q;
  logic                  have_q, go_q, v1_q, v2_q;
  logic [EW-1:0]         idx1_q, idx2_q;
  logic signed [31:0]    prod_q;
  logic signed [15:0]    val_q;
  logic                  last_q;
  logic [EW-1:0]         best_q;
  logic signed [ACC_W-1:0] best_val_q;
  logic [EW-1:0]         chosen_idx_q [MAX_SELECT];
  logic signed [ACC_W-1:0] chosen_val_q [MAX_SELECT];
  logic [16:0]           ex_q [MAX_SELECT];
  logic [SW-1:0]         sum_q;
  logic [13:0]           y_q;

  logic                  res_valid_q, final_q;
  logic [3:0]            res_idx_q;
  logic [15:0]           res_gate_q;
  logic [1:0]            res_rank_q;
  logic [31:0]           res_usage_q;

  logic [ECW-1:0]        n_exp;
  logic [SCW-1:0]        n_sel;
  int                    sel_tmp;
  logic                  issue, k_last, e_last;
  logic signed [ACC_W-1:0] cur_val, nv;
  logic [EW-1:0]         cur_idx, nb;
  logic                  better;
  logic [ACC_W-1:0]      gap;
  logic [31:0]           xr;
  logic [12:0]           xc;
  logic [16:0]           t0, t1, v, e_val;
  logic [11:0]           dlt;
  logic [EW-1:0]         id;
  logic [31:0]           u_cur, u_new;
  logic                  div_done;
  logic [NW-1:0]         div_quo, div_num;
  logic [15:0]           gate;

  // clamp the configured counts to what the hardware holds
  always_comb begin
    if (expert_count_i == 5'd0) n_exp = ECW'(1);
    else if (int'(expert_count_i) > MAX_EXPERTS) n_exp = ECW'(MAX_EXPERTS);
    else n_exp = ECW'(expert_count_i);
    sel_tmp = (select_count_i == 3'd0) ? 1 : int'(select_count_i);
    if (sel_tmp > MAX_SELECT) sel_tmp = MAX_SELECT;
    if (sel_tmp > int'(n_exp)) sel_tmp = int'(n_exp);
    n_sel = SCW'(sel_tmp);
  end

  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;
  assign issue   = (state_q == ST_ACC) && (e_q < n_exp);
  assign k_last  = (int'(k_q) == int'(n_sel) - 1);
  assign e_last  = (e_q == n_exp - ECW'(1));
  assign cur_idx = e_q[EW-1:0];
  assign raddr   = AW'(pos_q) * AW'(MAX_EXPERTS) + AW'(e_q);
  assign waddr   = AW'(q_item_i.row) * AW'(MAX_EXPERTS) + AW'(q_item_i.col);
  assign wr_en   = q_pop_o && (q_item_i.op == OP_WRITE);

  // running top-k scan: strict greater keeps the lower index on ties
  assign cur_val = acc_q[cur_idx];
  assign better  = !taken_q[cur_idx] && (!have_q || (cur_val > best_val_q));
  assign nb      = better ? cur_idx : best_q;
  assign nv      = better ? cur_val : best_val_q;

  // distance to the top logit, then exp via the 2^-x table
  assign gap   = chosen_val_q[0] - chosen_val_q[k_q];
  assign xr    = gap[ACC_W-1:8];
  assign xc    = (xr > 32'(DIFF_LIMIT)) ? 13'(DIFF_LIMIT) : xr[12:0];
  assign t0    = pow2_frac({1'b0, y_q[7:4]});
  assign t1    = pow2_frac({1'b0, y_q[7:4]} + 5'd1);
  assign dlt   = 12'(t0 - t1);
  assign v     = t0 - 17'((16'(dlt) * 16'(y_q[3:0])) >> 4);
  assign e_val = v >> y_q[13:8];

  assign id      = chosen_idx_q[k_q];
  assign u_cur   = usage_q[id];
  assign u_new   = (&u_cur) ? u_cur : u_cur + 32'd1;
  assign div_num = NW'({ex_q[k_q], 16'b0}) + NW'(sum_q >> 1);
  assign gate    = (|div_quo[NW-1:16]) ? 16'hFFFF : div_quo[15:0];

  tsgr_div #(
    .NW (NW),
    .DW (SW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q),
    .num_i   (div_num),
    .den_i   (sum_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) wmem[waddr] <= q_item_i.value;
    rdata_q <= wmem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      e_q         <= '0;
      k_q         <= '0;
      taken_q     <= '0;
      have_q      <= 1'b0;
      go_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < MAX_EXPERTS; i++) begin
        acc_q[i]   <= '0;
        usage_q[i] <= '0;
      end
    end else begin
      res_valid_q <= 1'b0;
      go_q        <= 1'b0;
      v1_q        <= issue;
      v2_q        <= v1_q;
      if (v2_q) acc_q[idx2_q] <= acc_q[idx2_q] + {{8{prod_q[31]}}, prod_q};
      case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            case (q_item_i.op)
              OP_CLEAR: begin
                for (int i = 0; i < MAX_EXPERTS; i++) usage_q[i] <= '0;
              end
              OP_ELEMENT: begin
                e_q <= '0;
                if (int'(pos_q) < MAX_MODEL_WIDTH) begin
                  state_q <= ST_ACC;
                end else if (q_item_i.last) begin
                  state_q <= ST_SEL;
                  k_q     <= '0;
                  taken_q <= '0;
                  have_q  <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_ACC: begin
          if (issue) begin
            e_q <= e_q + ECW'(1);
          end else if (!v1_q && !v2_q) begin
            // all products of this element are in
            pos_q <= pos_q + PW'(1);
            e_q   <= '0;
            if (last_q) begin
              state_q <= ST_SEL;
              k_q     <= '0;
              taken_q <= '0;
              have_q  <= 1'b0;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_SEL: begin
          if (e_last) begin
            taken_q[nb] <= 1'b1;
            have_q      <= 1'b0;
            e_q         <= '0;
            if (k_last) begin
              k_q     <= '0;
              state_q <= ST_EXPA;
            end else begin
              k_q <= k_q + KW'(1);
            end
          end else begin
            have_q <= have_q | better;
            e_q    <= e_q + ECW'(1);
          end
        end
        ST_EXPA: state_q <= ST_EXPB;
        ST_EXPB: begin
          if (k_last) begin
            k_q     <= '0;
            go_q    <= 1'b1;
            state_q <= ST_DIV;
          end else begin
            k_q     <= k_q + KW'(1);
            state_q <= ST_EXPA;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res_valid_q <= 1'b1;
            usage_q[id] <= u_new;
            if (k_last) begin
              // token done: drop the logits and restart the position
              for (int i = 0; i < MAX_EXPERTS; i++) acc_q[i] <= '0;
              pos_q   <= '0;
              k_q     <= '0;
              state_q <= ST_IDLE;
            end else begin
              k_q  <= k_q + KW'(1);
              go_q <= 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= cur_idx;
    idx2_q <= idx1_q;
    prod_q <= val_q * $signed(rdata_q);
    if (q_pop_o) begin
      val_q  <= q_item_i.value;
      last_q <= q_item_i.last;
    end
    if (state_q == ST_SEL) begin
      best_q     <= nb;
      best_val_q <= nv;
      if (e_last) begin
        chosen_idx_q[k_q] <= nb;
        chosen_val_q[k_q] <= nv;
      end
    end
    if (state_q == ST_EXPA) begin
      y_q <= 14'((30'(xc) * 30'(LOG2E_Q16) + 30'd32768) >> 16);
      if (k_q == '0) sum_q <= '0;
    end
    if (state_q == ST_EXPB) begin
      ex_q[k_q] <= e_val;
      sum_q     <= sum_q + SW'(e_val);
    end
    if (state_q == ST_DIV && div_done) begin
      res_idx_q   <= 4'(id);
      res_gate_q  <= gate;
      res_rank_q  <= 2'(k_q);
      res_usage_q <= u_new;
      final_q     <= k_last;
    end
  end

  assign result_valid_o = res_valid_q;
  assign expert_index_o = res_idx_q;
  assign gate_weight_o  = res_gate_q;
  assign rank_o         = res_rank_q;
  assign usage_count_o  = res_usage_q;
  assign final_choice_o = final_q;

  `TSGR_ASSERT_IMP(a_done_in_div, div_done, state_q == ST_DIV)
  `TSGR_ASSERT_NXT(a_done_gives_result, div_done, res_valid_q)
  `TSGR_ASSERT_IMP(a_final_ends_token, res_valid_q && final_q, state_q == ST_IDLE && pos_q == '0)
  `TSGR_ASSERT_IMP(a_drain_in_acc, v2_q, state_q == ST_ACC)

endmodule

@@ hdl/topk_softmax_gating_router_core.sv @@
// Top-k softmax gating router for a mixture of experts.
// Input channel: an item is transferred at a clock edge with start high and
// busy low. Opcode 0 writes one router weight, opcode 1 feeds one Q8.8 token
// element (last marks the end of the token), opcode 2 clears the usage
// counters; opcode 3 is taken and dropped. A two-entry queue sits between
// the front end and the execution unit, so busy rises only when it is full.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 expert count,
// 1 select count) and cfg_data_i; ready is always high. Write while idle.
// Processing: an element reads one weight a cycle from the weight memory, then
// multiplies and accumulates; a last element adds the top-k scan, the exp
// table and the bit-serial gate divider, which runs once per chosen expert.
// Results: result_valid_o strobes for one cycle per chosen expert, highest
// logit first; the receiver cannot stall, so each result is shown once.
// Reset clears logits, position and usage counters and sets expert count 16
// and select count 2; weights are undefined until written.
module topk_softmax_gating_router_core #(
  parameter int MAX_EXPERTS     = 16,
  parameter int MAX_MODEL_WIDTH = 256,
  parameter int MAX_SELECT      = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic [7:0]         weight_row_i,
  input  logic [3:0]         weight_expert_i,
  input  logic signed [15:0] value_i,
  input  logic               last_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output logic               result_valid_o,
  output logic [3:0]         expert_index_o,
  output logic [15:0]        gate_weight_o,
  output logic [1:0]         rank_o,
  output logic [31:0]        usage_count_o,
  output logic               final_choice_o
);
  import tsgr_pkg::*;

  logic [4:0] expert_count_q;
  logic [2:0] select_count_q;
  logic       q_valid, q_pop;
  item_t      q_item;

  assign cfg_ready_o = 1'b1;

  // hold the registers; writes to unknown indices are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expert_count_q <= 5'd16;
      select_count_q <= 3'd2;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_EXPERT_COUNT: expert_count_q <= cfg_data_i[4:0];
        CFG_SELECT_COUNT: select_count_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  tsgr_front #(
    .MAX_EXPERTS     (MAX_EXPERTS),
    .MAX_MODEL_WIDTH (MAX_MODEL_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .weight_row_i    (weight_row_i),
    .weight_expert_i (weight_expert_i),
    .value_i         (value_i),
    .last_i          (last_i),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_pop_i         (q_pop)
  );

  tsgr_back #(
    .MAX_EXPERTS     (MAX_EXPERTS),
    .MAX_MODEL_WIDTH (MAX_MODEL_WIDTH),
    .MAX_SELECT      (MAX_SELECT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .expert_count_i (expert_count_q),
    .select_count_i (select_count_q),
    .result_valid_o (result_valid_o),
    .expert_index_o (expert_index_o),
    .gate_weight_o  (gate_weight_o),
    .rank_o         (rank_o),
    .usage_count_o  (usage_count_o),
    .final_choice_o (final_choice_o)
  );

endmodule
